// File: rtl/wrus_pkg.sv
package wrus_pkg;

  localparam int ENTRIES    = 8;
  localparam int WEIGHT_MAX = 100;
  localparam int IDX_W      = 3;
  localparam int W_W        = 7;
  localparam int CNT_W      = 4;
  localparam int DRAW_W     = 31;
  localparam int WPACK_W    = 56;
  localparam int SUM_W      = $clog2(ENTRIES * WEIGHT_MAX + 1);
  localparam int STEP_W     = $clog2(DRAW_W);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 64;

  typedef enum logic {
    OP_PICK       = 1'b0,
    OP_SET_ONLINE = 1'b1
  } op_t;

  typedef enum logic {
    REG_ENTRY_COUNT = 1'b0,
    REG_WEIGHTS     = 1'b1
  } reg_t;

  typedef struct packed {
    logic [ENTRIES-1:0] flags;
    logic [DRAW_W-1:0]  weight_draw;
    logic [DRAW_W-1:0]  backup_draw;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] chosen_index;
    logic             from_backup;
  } res_t;

  function automatic logic [W_W-1:0] weight_of(input logic [WPACK_W-1:0] wp,
                                               input int unsigned i);
    logic [W_W-1:0] w;
    w = wp[W_W*i +: W_W];
    return (w > W_W'(WEIGHT_MAX)) ? W_W'(WEIGHT_MAX) : w;
  endfunction

  function automatic logic [CNT_W-1:0] entries_in_use(input logic [CNT_W-1:0] cnt);
    return (cnt > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : cnt;
  endfunction

endpackage

// File: rtl/wrus_front.sv
module wrus_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic                         q_full,
  input  logic                         in_operation,
  input  logic [wrus_pkg::IDX_W-1:0]   in_entry_index,
  input  logic                         in_online_flag,
  input  logic [wrus_pkg::DRAW_W-1:0]  in_weight_draw,
  input  logic [wrus_pkg::DRAW_W-1:0]  in_backup_draw,
  output logic                         q_push,
  output wrus_pkg::cmd_t               q_cmd
);

  logic [wrus_pkg::ENTRIES-1:0] flags_r, flags_nxt;
  logic                         accept;
  wrus_pkg::op_t                op;

  assign op     = wrus_pkg::op_t'(in_operation);
  assign accept = push && !q_full;
  assign q_push = accept && (op == wrus_pkg::OP_PICK);

  always_comb begin
    flags_nxt = flags_r;
    if (accept && (op == wrus_pkg::OP_SET_ONLINE) &&
        ({1'b0, in_entry_index} < (wrus_pkg::IDX_W+1)'(wrus_pkg::ENTRIES))) begin
      flags_nxt[in_entry_index] = in_online_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  // snapshot flags so queued picks see them as of their own beat
  assign q_cmd.flags       = flags_r;
  assign q_cmd.weight_draw = in_weight_draw;
  assign q_cmd.backup_draw = in_backup_draw;

endmodule

// File: rtl/wrus_cmdq.sv
module wrus_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  wrus_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output wrus_pkg::cmd_t rd_cmd
);

  wrus_pkg::cmd_t                mem_r [wrus_pkg::QDEPTH];
  logic [wrus_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [wrus_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          do_wr, do_rd;

  assign full     = (cnt_r == wrus_pkg::QCNT_W'(wrus_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// File: rtl/wrus_back.sv
module wrus_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  wrus_pkg::cmd_t                cmd,
  output logic                          cmd_take,
  input  logic [wrus_pkg::CNT_W-1:0]    entry_count,
  input  logic [wrus_pkg::WPACK_W-1:0]  weights,
  input  logic                          pop,
  output logic                          empty,
  output wrus_pkg::res_t                res
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [wrus_pkg::ENTRIES-1:0]    elig_r, elig_nxt;
  logic                            mode_r, mode_nxt;
  logic [wrus_pkg::SUM_W-1:0]      rem_r, rem_nxt;
  logic [wrus_pkg::SUM_W-1:0]      div_r, div_nxt;
  logic [wrus_pkg::DRAW_W-1:0]     q_r, q_nxt;
  logic [wrus_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [wrus_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  wrus_pkg::res_t                  hold_r, hold_nxt;
  wrus_pkg::res_t                  out_r, out_nxt;

  logic [wrus_pkg::CNT_W-1:0]      n_use;
  logic [wrus_pkg::ENTRIES-1:0]    elig;
  logic [wrus_pkg::SUM_W-1:0]      sum;
  logic [wrus_pkg::CNT_W-1:0]      bcnt;
  logic [wrus_pkg::SUM_W:0]        trial;
  logic [wrus_pkg::W_W-1:0]        w_scan;
  logic                            cls;
  logic [wrus_pkg::SUM_W-1:0]      unit;
  logic                            out_free;

  assign n_use    = wrus_pkg::entries_in_use(entry_count);
  assign out_free = !out_valid_r || pop;
  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign empty    = !out_valid_r;
  assign res      = out_r;

  always_comb begin
    logic [wrus_pkg::W_W-1:0] w;
    sum  = '0;
    bcnt = '0;
    for (int i = 0; i < wrus_pkg::ENTRIES; i++) begin
      w       = wrus_pkg::weight_of(weights, i);
      elig[i] = cmd.flags[i] && (wrus_pkg::CNT_W'(i) < n_use);
      if (elig[i] && (w != '0)) begin
        sum = sum + wrus_pkg::SUM_W'(w);
      end
      if (elig[i] && (w == '0)) begin
        bcnt = bcnt + 1'b1;
      end
    end
  end

  assign trial  = {rem_r, q_r[wrus_pkg::DRAW_W-1]};
  assign w_scan = wrus_pkg::weight_of(weights, int'(idx_r));
  assign cls    = mode_r ? (w_scan == '0) : (w_scan != '0);
  assign unit   = mode_r ? wrus_pkg::SUM_W'(1) : wrus_pkg::SUM_W'(w_scan);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !pop;
    elig_nxt      = elig_r;
    mode_nxt      = mode_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    hold_nxt      = hold_r;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          elig_nxt = elig;
          rem_nxt  = '0;
          step_nxt = '0;
          idx_nxt  = '0;
          if (sum != '0) begin
            mode_nxt  = 1'b0;
            div_nxt   = sum;
            q_nxt     = cmd.weight_draw;
            state_nxt = S_DIV;
          end else if (bcnt != '0) begin
            mode_nxt  = 1'b1;
            div_nxt   = wrus_pkg::SUM_W'(bcnt);
            q_nxt     = cmd.backup_draw;
            state_nxt = S_DIV;
          end else begin
            hold_nxt  = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = wrus_pkg::SUM_W'(trial - {1'b0, div_r});
        end else begin
          rem_nxt = trial[wrus_pkg::SUM_W-1:0];
        end
        q_nxt    = q_r << 1;
        step_nxt = step_r + 1'b1;
        if (step_r == wrus_pkg::STEP_W'(wrus_pkg::DRAW_W - 1)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (elig_r[idx_r] && cls && (rem_r < unit)) begin
          hold_nxt.found        = 1'b1;
          hold_nxt.chosen_index = idx_r;
          hold_nxt.from_backup  = mode_r;
          state_nxt             = S_DONE;
        end else begin
          if (elig_r[idx_r] && cls) begin
            rem_nxt = rem_r - unit;
          end
          if (idx_r == wrus_pkg::IDX_W'(wrus_pkg::ENTRIES - 1)) begin
            hold_nxt  = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt       = hold_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elig_r <= elig_nxt;
    mode_r <= mode_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

endmodule

// File: rtl/weighted_random_upstream_select.sv
// A pick passes through the command queue to the back end: a 31-step restoring divider
// reduces its draw modulo the eligible weight sum (backup draw modulo the eligible
// zero-weight count), then a scan of up to 8 entries runs one per cycle. The next pick is
// taken only once the last result is in the output register; flag writes take one beat
// per cycle while the command queue has room.
// Reset (synchronous, rst_n low): all entries offline, config registers zero, queues empty.
module weighted_random_upstream_select (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_operation,
  input  logic [wrus_pkg::IDX_W-1:0]    in_entry_index,
  input  logic                          in_online_flag,
  input  logic [wrus_pkg::DRAW_W-1:0]   in_weight_draw,
  input  logic [wrus_pkg::DRAW_W-1:0]   in_backup_draw,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_found,
  output logic [wrus_pkg::IDX_W-1:0]    out_chosen_index,
  output logic                          out_from_backup,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wrus_pkg::CFG_AW-1:0]   paddr,
  input  logic [wrus_pkg::CFG_DW-1:0]   pwdata,
  output logic [wrus_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  logic [wrus_pkg::CNT_W-1:0]    entry_count_r;
  logic [wrus_pkg::WPACK_W-1:0]  weights_r;
  wrus_pkg::reg_t                reg_sel;
  logic                          cfg_wr;
  logic                          q_push, q_valid, q_take;
  wrus_pkg::cmd_t                q_wr_cmd, q_rd_cmd;
  wrus_pkg::res_t                res;

  assign pready  = 1'b1;
  assign reg_sel = wrus_pkg::reg_t'(paddr[3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      weights_r     <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        wrus_pkg::REG_ENTRY_COUNT: entry_count_r <= pwdata[wrus_pkg::CNT_W-1:0];
        wrus_pkg::REG_WEIGHTS:     weights_r     <= pwdata[wrus_pkg::WPACK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      wrus_pkg::REG_ENTRY_COUNT:
        prdata = {{(wrus_pkg::CFG_DW-wrus_pkg::CNT_W){1'b0}}, entry_count_r};
      wrus_pkg::REG_WEIGHTS:
        prdata = {{(wrus_pkg::CFG_DW-wrus_pkg::WPACK_W){1'b0}}, weights_r};
      default:
        prdata = '0;
    endcase
  end

  wrus_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .q_full         (full),
    .in_operation   (in_operation),
    .in_entry_index (in_entry_index),
    .in_online_flag (in_online_flag),
    .in_weight_draw (in_weight_draw),
    .in_backup_draw (in_backup_draw),
    .q_push         (q_push),
    .q_cmd          (q_wr_cmd)
  );

  wrus_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_cmd   (q_wr_cmd),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_cmd   (q_rd_cmd)
  );

  wrus_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_valid),
    .cmd         (q_rd_cmd),
    .cmd_take    (q_take),
    .entry_count (entry_count_r),
    .weights     (weights_r),
    .pop         (pop),
    .empty       (empty),
    .res         (res)
  );

  assign out_found        = res.found;
  assign out_chosen_index = res.chosen_index;
  assign out_from_backup  = res.from_backup;

`ifndef SYNTH
  a_backup_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_from_backup) |-> out_found)
    else $error("backup result without a chosen entry");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_found) |-> ((out_chosen_index == '0) && !out_from_backup))
    else $error("empty pick carries nonzero fields");

  a_chosen_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_found) |->
      ({1'b0, out_chosen_index} < wrus_pkg::entries_in_use(entry_count_r)))
    else $error("chosen entry outside the entries in use");
`endif

endmodule
